[rtl/wsm_pkg.sv]
`default_nettype none
package wsm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // pattern store as laid out in the two 64-bit registers
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_INDEX_WIDTH = 4;
   localparam int WORD_WIDTH = 64;
   localparam int LENGTH_WIDTH = 5;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 5'd1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [7:0] WILDCARD_BYTE = 8'h5F;

   typedef struct packed {
      logic [PATTERN_BYTES-1:0][7:0] bytes;
      logic [LENGTH_WIDTH-1:0] length;
   } pattern_type;

   typedef struct packed {
      logic valid;
      logic has_byte;
      logic end_of_line;
      logic [7:0] text_byte;
   } item_type;

endpackage
`default_nettype wire

[rtl/wsm_csr.sv]
`default_nettype none
module wsm_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic write_en,
   input  wire logic [wsm_pkg::CSR_INDEX_WIDTH-1:0] write_index,
   input  wire logic [wsm_pkg::WORD_WIDTH-1:0] write_data,
   output wsm_pkg::pattern_type pattern
);

   logic [wsm_pkg::WORD_WIDTH-1:0] low_ff, low_in;
   logic [wsm_pkg::WORD_WIDTH-1:0] high_ff, high_in;
   logic [wsm_pkg::LENGTH_WIDTH-1:0] length_ff, length_in;

   always_comb begin
      low_in = low_ff;
      high_in = high_ff;
      length_in = length_ff;
      if (write_en) begin
         unique case (write_index)
            wsm_pkg::CSR_PATTERN_LOW: low_in = write_data;
            wsm_pkg::CSR_PATTERN_HIGH: high_in = write_data;
            wsm_pkg::CSR_PATTERN_LENGTH: length_in = write_data[wsm_pkg::LENGTH_WIDTH-1:0];
            default: ; // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         high_ff <= '0;
         length_ff <= wsm_pkg::LENGTH_RESET;
      end else begin
         low_ff <= low_in;
         high_ff <= high_in;
         length_ff <= length_in;
      end
   end

   assign pattern.bytes = {high_ff, low_ff};
   assign pattern.length = length_ff;

endmodule
`default_nettype wire

[rtl/wsm_match.sv]
`default_nettype none
module wsm_match #(
   parameter int MAX_PATTERN = wsm_pkg::MAX_PATTERN_DEFAULT,
   parameter int COUNT_WIDTH = wsm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire wsm_pkg::item_type item,
   input  wire wsm_pkg::pattern_type pattern,
   output logic [COUNT_WIDTH-1:0] count_next
);

   localparam int SEEN_WIDTH = $clog2(MAX_PATTERN + 1);
   localparam int LW = wsm_pkg::LENGTH_WIDTH;

   logic [MAX_PATTERN-1:0][7:0] window_ff, window_in;
   logic [SEEN_WIDTH-1:0] seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [LW-1:0] eff_length;
   logic [MAX_PATTERN-1:0] pos_ok;
   logic hit;

   // clamp the configured length into 1..MAX_PATTERN
   always_comb begin
      priority if (pattern.length == '0) begin
         eff_length = LW'(1);
      end else if (pattern.length > LW'(MAX_PATTERN)) begin
         eff_length = LW'(MAX_PATTERN);
      end else begin
         eff_length = pattern.length;
      end
   end

   always_comb begin
      window_in[0] = item.text_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   assign seen_in = (seen_ff < SEEN_WIDTH'(MAX_PATTERN)) ? seen_ff + SEEN_WIDTH'(1) : seen_ff;

   // window age k lines up with pattern byte eff_length-1-k
   always_comb begin
      logic [LW-1:0] pidx;
      logic [7:0] pbyte;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pidx = eff_length - LW'(1) - LW'(k);
         pbyte = pattern.bytes[pidx[wsm_pkg::PATTERN_INDEX_WIDTH-1:0]];
         pos_ok[k] = (LW'(k) >= eff_length) || (pbyte == wsm_pkg::WILDCARD_BYTE)
                     || (pbyte == window_in[k]);
      end
   end

   assign hit = item.has_byte && (&pos_ok) && (LW'(seen_in) >= eff_length);

   always_comb begin
      count_next = count_ff;
      if (hit && (count_ff != '1)) begin
         count_next = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (step) begin
         count_in = item.end_of_line ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (step && item.has_byte) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (step) begin
            if (item.end_of_line) begin
               seen_ff <= '0;
            end else if (item.has_byte) begin
               seen_ff <= seen_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

[rtl/wildcard_substring_match_count_core.sv]
`default_nettype none
// Path: an accepted item is held in item_ff and processed there; a line's count
// shows on rsp_valid, through rsp_valid_ff, once its closing item steps out of item_ff.
// Throughput: one item per cycle, set by the combinational window compare; a closing
// item waits while a stalled count still holds the result register.
// Reset clears line state and count, pattern bytes to zero, pattern length to 1.
module wildcard_substring_match_count_core #(
   parameter int MAX_PATTERN = wsm_pkg::MAX_PATTERN_DEFAULT,
   parameter int COUNT_WIDTH = wsm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic req_has_byte,
   input  wire logic req_end_of_line,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [COUNT_WIDTH-1:0] rsp_match_count,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [wsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [wsm_pkg::WORD_WIDTH-1:0] csr_write_data
);

   wsm_pkg::pattern_type pattern;
   wsm_pkg::item_type item_ff, item_in;
   logic out_free, step, req_accept;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic [COUNT_WIDTH-1:0] count_next;

   assign csr_ready = 1'b1;

   wsm_csr u_csr (
      .clock(clock),
      .reset(reset),
      .write_en(csr_valid && csr_ready),
      .write_index(csr_index),
      .write_data(csr_write_data),
      .pattern(pattern)
   );

   // an item that closes a line needs the result register free
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step = item_ff.valid && (!item_ff.end_of_line || out_free);
   assign req_stall = item_ff.valid && !step;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.valid = 1'b1;
         item_in.text_byte = req_text_byte;
         item_in.has_byte = req_has_byte;
         item_in.end_of_line = req_end_of_line;
      end else if (step) begin
         item_in.valid = 1'b0;
      end
   end

   wsm_match #(
      .MAX_PATTERN(MAX_PATTERN),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_match (
      .clock(clock),
      .reset(reset),
      .step(step),
      .item(item_ff),
      .pattern(pattern),
      .count_next(count_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step && item_ff.end_of_line) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         item_ff <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && item_ff.end_of_line) begin
         rsp_count_ff <= count_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule
`default_nettype wire
